@@ rtl/core/msc_pkg.sv @@
// Shared types and constants of the Manhattan nearest-site classifier.
// Holds the request codes, the search token that walks the cell chain and
// the status struct of the area unit. No dependencies.
`default_nettype none

package msc_pkg;

	localparam int MAX_SITES_DEF = 64;
	localparam int COORD_MAX     = 1023;
	localparam int COORD_W       = 10;
	localparam int IDX_W         = 6;
	localparam int DIST_W        = 11;
	localparam int AREA_W        = 21;
	localparam int CNT_W         = 7;

	localparam logic [AREA_W-1:0] AREA_TOP = 21'd1048576;

	typedef enum logic [1:0] {
		REQ_LOAD     = 2'd0,
		REQ_CLASSIFY = 2'd1,
		REQ_READ     = 2'd2
	} req_kind_t;

	// Search token: request fields plus the running minimum.
	typedef struct packed {
		req_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [CNT_W-1:0]   n;
		logic [DIST_W-1:0]  best;
		logic [CNT_W-1:0]   near;
		logic               tie;
		logic               have;
	} tok_t;

	typedef struct packed {
		logic clearing;
		logic done;
	} area_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/msc_req_if.sv @@
// Request channel of the nearest-site classifier: valid/ready plus payload.
// Standalone; no package needed.
`default_nettype none

interface msc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [5:0] site_index;
	logic [9:0] coord_x;
	logic [9:0] coord_y;

	modport source (output valid, output req_type, output site_index,
		output coord_x, output coord_y, input ready);
	modport sink (input valid, input req_type, input site_index,
		input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

@@ rtl/core/msc_rsp_if.sv @@
// Response channel of the nearest-site classifier: valid/ready plus payload.
// Standalone; no package needed.
`default_nettype none

interface msc_rsp_if;
	logic        valid;
	logic        ready;
	logic [5:0]  nearest_site;
	logic        tie_flag;
	logic [10:0] min_distance;
	logic [20:0] area_total;

	modport source (output valid, output nearest_site, output tie_flag,
		output min_distance, output area_total, input ready);
	modport sink (input valid, input nearest_site, input tie_flag,
		input min_distance, input area_total, output ready);
endinterface

`default_nettype wire

@@ rtl/core/msc_cell.sv @@
// One cell of the site chain: stores one site and updates the passing token.
// Depends on msc_pkg.
`default_nettype none

module msc_cell import msc_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_vld,
	input  tok_t up_tok,
	output logic dn_vld,
	output tok_t dn_tok
);

	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic [DIST_W-1:0]  site_dist;
	logic               here;
	tok_t               nxt;
	logic               vld_s1;
	tok_t               tok_s1;

	always_comb begin
		dx        = (up_tok.px > x_q) ? (up_tok.px - x_q) : (x_q - up_tok.px);
		dy        = (up_tok.py > y_q) ? (up_tok.py - y_q) : (y_q - up_tok.py);
		site_dist = {1'b0, dx} + {1'b0, dy};
		here      = 32'(up_tok.n) > CELL_IDX;
		nxt       = up_tok;
		if (up_tok.kind == REQ_CLASSIFY && here) begin
			// strict less keeps the lowest index on equal distance
			if (!up_tok.have || site_dist < up_tok.best) begin
				nxt.have = 1'b1;
				nxt.best = site_dist;
				nxt.near = CNT_W'(CELL_IDX);
				nxt.tie  = 1'b0;
			end else if (site_dist == up_tok.best) begin
				nxt.tie = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_vld && up_tok.kind == REQ_LOAD && 32'(up_tok.idx) == CELL_IDX) begin
			x_q <= up_tok.px;
			y_q <= up_tok.py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= nxt;
	end

	assign dn_vld = vld_s1;
	assign dn_tok = tok_s1;

endmodule

`default_nettype wire

@@ rtl/core/msc_area.sv @@
// Area counter unit at the end of the chain: counter memory, clearing pass
// after reset, read-modify-write of the winner and the response register.
// Depends on msc_pkg and msc_rsp_if.
`default_nettype none

module msc_area import msc_pkg::*; #(
	parameter int MAX_SITES = MAX_SITES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_vld,
	input  tok_t      up_tok,
	msc_rsp_if.source rsp,
	output area_sts_t sts
);

	localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	tok_t               hold_q;
	logic [AREA_W-1:0]  mem [MAX_SITES];
	logic [AREA_W-1:0]  rd_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [AREA_W-1:0]  wr_data;
	logic [AREA_W-1:0]  bumped;
	logic               deliver;
	logic               upd;
	logic               idx_ok;
	logic [IDX_W-1:0]   res_near;
	logic               res_tie;
	logic [DIST_W-1:0]  res_dist;
	logic [AREA_W-1:0]  res_area;
	logic               rsp_vld_q;
	logic [IDX_W-1:0]   rsp_near_q;
	logic               rsp_tie_q;
	logic [DIST_W-1:0]  rsp_dist_q;
	logic [AREA_W-1:0]  rsp_area_q;

	assign deliver = (state_q == S_READ) && (!rsp_vld_q || rsp.ready);
	assign idx_ok  = 32'(hold_q.idx) < MAX_SITES;
	assign bumped  = (rd_q < AREA_TOP) ? (rd_q + AREA_W'(1)) : rd_q;
	assign rd_en   = (state_q == S_IDLE) && up_vld;
	assign rd_addr = (up_tok.kind == REQ_CLASSIFY) ? AW'(32'(up_tok.near))
		: AW'(32'(up_tok.idx));

	always_comb begin
		res_near = '0;
		res_tie  = 1'b0;
		res_dist = '0;
		res_area = '0;
		upd      = 1'b0;
		case (hold_q.kind)
			REQ_CLASSIFY: begin
				res_near = hold_q.near[IDX_W-1:0];
				res_tie  = hold_q.tie;
				res_dist = hold_q.best;
				if (!hold_q.tie) begin
					upd      = 1'b1;
					res_area = bumped;
				end
			end
			REQ_READ: begin
				if (idx_ok) res_area = rd_q;
			end
			default: begin
				res_area = '0;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = deliver && upd;
			wr_addr = AW'(32'(hold_q.near));
			wr_data = bumped;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rd_en) hold_q <= up_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			rsp_vld_q  <= 1'b0;
			rsp_near_q <= '0;
			rsp_tie_q  <= 1'b0;
			rsp_dist_q <= '0;
			rsp_area_q <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready && !deliver) rsp_vld_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_SITES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (up_vld) state_q <= S_READ;
				end
				S_READ: begin
					// hold the read data until the response register frees
					if (deliver) begin
						state_q    <= S_IDLE;
						rsp_vld_q  <= 1'b1;
						rsp_near_q <= res_near;
						rsp_tie_q  <= res_tie;
						rsp_dist_q <= res_dist;
						rsp_area_q <= res_area;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.nearest_site = rsp_near_q;
	assign rsp.tie_flag     = rsp_tie_q;
	assign rsp.min_distance = rsp_dist_q;
	assign rsp.area_total   = rsp_area_q;

	assign sts.clearing = (state_q == S_CLEAR);
	assign sts.done     = deliver;

	a_tok_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		up_vld |-> state_q == S_IDLE)
		else $error("token reached area unit while it was busy");

	a_tie_no_area: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_tie_q) |-> rsp_area_q == '0)
		else $error("tie beat carries a nonzero area");

	a_rd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && !deliver) |=> $stable(rd_q))
		else $error("counter read data changed while waiting on the output");

endmodule

`default_nettype wire

@@ rtl/core/manhattan_nearest_site_classifier.sv @@
// Top level of the Manhattan nearest-site classifier: request entry, cell
// chain and area unit. Depends on msc_pkg, msc_req_if, msc_rsp_if, msc_cell
// and msc_area.
//
// Usage: requests arrive as beats on req (load site, classify point, read
// site area), one response beat per request leaves on rsp. The user writes
// sites_in_use through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. Every request token walks a chain of
// MAX_SITES cells, one cell per cycle, each cell holding one site and
// folding its distance into the token; the area unit then does a registered
// read and, for a classify without a tie, a write-back of the counter.
// A new request is taken only once the previous result is registered.
// After reset the area counters are cleared in a pass over all MAX_SITES
// entries, during which req.ready stays low; the site table is not cleared.
// When rsp stalls, the response beat holds in its register and the next
// request is still taken; its result waits in the area unit until the
// register frees.
`default_nettype none

module manhattan_nearest_site_classifier import msc_pkg::*; #(
	parameter int MAX_SITES = MAX_SITES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	msc_req_if.sink          req,
	msc_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0]   sites_q;
	logic               busy_q;
	logic               accept;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;
	logic [CNT_W-1:0]   n_eff;
	logic [MAX_SITES:0] vld_c;
	tok_t               tok_c [MAX_SITES+1];
	area_sts_t          sts;

	assign req.ready = !busy_q && !sts.clearing;
	assign accept    = req.valid && req.ready;

	always_comb begin
		px = (32'(req.coord_x) > COORD_MAX) ? COORD_W'(COORD_MAX) : req.coord_x;
		py = (32'(req.coord_y) > COORD_MAX) ? COORD_W'(COORD_MAX) : req.coord_y;
		if (sites_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(sites_q) > MAX_SITES) begin
			n_eff = CNT_W'(MAX_SITES);
		end else begin
			n_eff = sites_q;
		end
	end

	always_comb begin
		tok_c[0]      = '0;
		tok_c[0].kind = req_kind_t'(req.req_type);
		tok_c[0].idx  = req.site_index;
		tok_c[0].px   = px;
		tok_c[0].py   = py;
		tok_c[0].n    = n_eff;
	end
	assign vld_c[0] = accept;

	for (genvar gi = 0; gi < MAX_SITES; gi++) begin : g_cell
		msc_cell #(
			.CELL_IDX(gi)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.up_vld (vld_c[gi]),
			.up_tok (tok_c[gi]),
			.dn_vld (vld_c[gi+1]),
			.dn_tok (tok_c[gi+1])
		);
	end

	msc_area #(
		.MAX_SITES(MAX_SITES)
	) u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.up_vld (vld_c[MAX_SITES]),
		.up_tok (tok_c[MAX_SITES]),
		.rsp    (rsp),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_q <= CNT_W'(1);
			busy_q  <= 1'b0;
		end else begin
			if (cfg_we) sites_q <= cfg_wdata;
			// hold busy from the accepted beat until its result is registered
			if (accept) begin
				busy_q <= 1'b1;
			end else if (sts.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_c) <= 1)
		else $error("more than one token in the cell chain");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[MAX_SITES] |-> busy_q)
		else $error("token left the chain with no request in flight");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !busy_q)
		else $error("block still busy after its result was registered");

endmodule

`default_nettype wire
